// ===== rtl/multichannel_fragment_reassembler_defines.svh =====
// Assertion macros used by the port-level checker of the fragment reassembler.
`ifndef MULTICHANNEL_FRAGMENT_REASSEMBLER_DEFINES_SVH
`define MULTICHANNEL_FRAGMENT_REASSEMBLER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define MFR_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// A condition that, once seen, forces a consequence at the next clock edge.
`define MFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/mfr_pkg.sv =====
// Shared types, codes and sizes of the multichannel fragment reassembler.
`default_nettype none
package mfr_pkg;

	// Default sizes handed to the top level parameters.
	localparam int NUM_CHANNELS_DEF      = 8;
	localparam int MAX_MESSAGE_BYTES_DEF = 4096;

	// Depth of the request queue between front and back, and of the result queue.
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;
	localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

	// Most requests that can be inside the block at once.
	localparam int MAX_PENDING = 1 + QUEUE_DEPTH + 1 + OUT_DEPTH;

	// Fragment kinds; any code with the top bit set is unknown.
	localparam logic [2:0] FK_SINGLE = 3'd0;
	localparam logic [2:0] FK_FIRST  = 3'd1;
	localparam logic [2:0] FK_CONT   = 3'd2;
	localparam logic [2:0] FK_LAST   = 3'd3;

	// Request actions.
	localparam logic ACT_FRAG = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Result kinds.
	typedef enum logic [1:0] {
		RK_PASS = 2'd0,
		RK_DONE = 2'd1,
		RK_ERR  = 2'd2,
		RK_READ = 2'd3
	} result_kind_t;

	// A classified request as it travels from the front to the back.
	typedef struct packed {
		logic        action;
		logic [7:0]  chan;
		logic        chan_ok;
		logic [2:0]  frag_kind;
		logic [7:0]  payload_byte;
		logic        frag_end;
		logic [11:0] read_offset;
		logic        offset_ok;
	} item_t;

	// One result as it waits in the output queue.
	typedef struct packed {
		logic [1:0]  result_kind;
		logic [7:0]  out_chan;
		logic [7:0]  out_byte;
		logic [12:0] message_length;
		logic        message_end;
	} rsp_t;

endpackage
`default_nettype wire

// ===== rtl/mfr_if.sv =====
// Request and result channel interfaces of the fragment reassembler.
`default_nettype none
interface mfr_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  chan;
	logic [2:0]  frag_kind;
	logic [7:0]  payload_byte;
	logic        frag_end;
	logic [11:0] read_offset;

	modport source (output valid, action, chan, frag_kind, payload_byte, frag_end,
		read_offset, input ready);
	modport sink (input valid, action, chan, frag_kind, payload_byte, frag_end,
		read_offset, output ready);
endinterface

interface mfr_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [7:0]  out_chan;
	logic [7:0]  out_byte;
	logic [12:0] message_length;
	logic        message_end;

	modport source (output valid, result_kind, out_chan, out_byte, message_length,
		message_end, input ready);
	modport sink (input valid, result_kind, out_chan, out_byte, message_length,
		message_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/mfr_fifo.sv =====
// Small synchronous FIFO used for the request queue and the result queue.
`default_nettype none
module mfr_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push_valid,
	output logic                              push_ready,
	input  wire logic [WIDTH-1:0]             push_data,
	output logic                              pop_valid,
	input  wire logic                         pop_ready,
	output logic [WIDTH-1:0]                  pop_data,
	output logic [$clog2(DEPTH+1)-1:0]        count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	// Handshakes on both sides.
	assign push_ready = (32'(count_q) < 32'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign count      = count_q;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/mfr_front.sv =====
// Front end: takes requests, checks channel and offset range, and registers them.
`default_nettype none
module mfr_front #(
	parameter int NUM_CHANNELS      = 8,
	parameter int MAX_MESSAGE_BYTES = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	mfr_req_if.sink             req,
	output logic                item_valid,
	input  wire logic           item_ready,
	output mfr_pkg::item_t      item
);
	import mfr_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	assign req.ready  = !valid_s1 || item_ready;
	assign accept     = req.valid && req.ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	// Stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !item_ready);
		end
	end

	// Classify the request while registering it.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action       <= req.action;
			item_s1.chan         <= req.chan;
			item_s1.chan_ok      <= (32'(req.chan) < 32'(NUM_CHANNELS));
			item_s1.frag_kind    <= req.frag_kind;
			item_s1.payload_byte <= req.payload_byte;
			item_s1.frag_end     <= req.frag_end;
			item_s1.read_offset  <= req.read_offset;
			item_s1.offset_ok    <= (32'(req.read_offset) < 32'(MAX_MESSAGE_BYTES));
		end
	end
endmodule
`default_nettype wire

// ===== rtl/mfr_back.sv =====
// Back end: per-channel reassembly state, the message store and result forming.
`default_nettype none
module mfr_back #(
	parameter int NUM_CHANNELS      = 8,
	parameter int MAX_MESSAGE_BYTES = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire mfr_pkg::item_t                  item,
	input  wire logic [mfr_pkg::OUT_CNT_W-1:0]   out_count,
	output logic                                 res_valid,
	output mfr_pkg::rsp_t                        res
);
	import mfr_pkg::*;

	localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int OFFW  = $clog2(MAX_MESSAGE_BYTES);
	localparam int BW    = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam int AW    = CHW + OFFW;
	localparam int DEPTH = NUM_CHANNELS * (2 ** OFFW);

	// Per-channel state.
	logic [BW-1:0]           held_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] asm_q;
	logic [NUM_CHANNELS-1:0] fail_q;
	logic [NUM_CHANNELS-1:0] open_q;

	// Message store, one region of 2**OFFW bytes per channel.
	logic [7:0] store_q [DEPTH];

	logic [CHW-1:0]  c;
	logic            fire;
	logic            frag_fire;
	logic [BW-1:0]   held_n;
	logic            asm_n;
	logic            fail_n;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;
	logic            emit;
	result_kind_t    rkind;
	logic [7:0]      rbyte;
	logic [12:0]     rlen;
	logic            rend;
	logic            use_mem;

	// Result stage.
	logic            res_valid_s1;
	rsp_t            res_s1;
	logic            use_mem_s1;
	logic [7:0]      rd_byte_s1;

	// Take a request only when the result queue has room for it.
	assign item_ready = (32'(out_count) + 32'(res_valid_s1)) < 32'(OUT_DEPTH);
	assign fire       = item_valid && item_ready;
	assign frag_fire  = fire && (item.action == ACT_FRAG) && item.chan_ok;
	assign c          = item.chan[CHW-1:0];
	assign rd_addr    = {c, OFFW'(item.read_offset)};

	// Reassembly decision for one request.
	always_comb begin
		held_n  = held_q[c];
		asm_n   = asm_q[c];
		fail_n  = fail_q[c];
		wr_en   = 1'b0;
		wr_addr = {c, held_q[c][OFFW-1:0]};
		emit    = 1'b0;
		rkind   = RK_PASS;
		rbyte   = 8'd0;
		rlen    = 13'd0;
		rend    = 1'b0;
		use_mem = 1'b0;
		if (item.action == ACT_READ) begin
			emit    = 1'b1;
			rkind   = RK_READ;
			use_mem = item.chan_ok && item.offset_ok;
		end else if (!item.chan_ok) begin
			emit  = item.frag_end;
			rkind = RK_ERR;
		end else if (item.frag_kind == FK_SINGLE) begin
			held_n = '0;
			asm_n  = 1'b0;
			fail_n = 1'b0;
			emit   = 1'b1;
			rkind  = RK_PASS;
			rbyte  = item.payload_byte;
			rend   = item.frag_end;
		end else begin
			// A first fragment outside an open fragment starts a new message.
			if (item.frag_kind == FK_FIRST && !open_q[c]) begin
				held_n = '0;
				fail_n = 1'b0;
				asm_n  = 1'b1;
			end
			if (item.frag_kind[2]) begin
				fail_n = 1'b1;
				held_n = '0;
				asm_n  = 1'b0;
			end else if (!fail_n) begin
				if (!asm_n) begin
					fail_n = 1'b1;
				end else if (32'(held_n) >= 32'(MAX_MESSAGE_BYTES)) begin
					fail_n = 1'b1;
					held_n = '0;
					asm_n  = 1'b0;
				end else begin
					wr_en   = 1'b1;
					wr_addr = {c, held_n[OFFW-1:0]};
					held_n  = held_n + 1'b1;
				end
			end
			// Report at the end of the fragment.
			if (item.frag_end) begin
				if (fail_n) begin
					fail_n = 1'b0;
					emit   = 1'b1;
					rkind  = RK_ERR;
				end else if (item.frag_kind == FK_LAST) begin
					emit   = 1'b1;
					rkind  = RK_DONE;
					rlen   = 13'(held_n);
					held_n = '0;
					asm_n  = 1'b0;
				end
			end
		end
	end

	// Control state and the result stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				held_q[i] <= '0;
			end
			asm_q        <= '0;
			fail_q       <= '0;
			open_q       <= '0;
			res_valid_s1 <= 1'b0;
		end else begin
			res_valid_s1 <= fire && emit;
			if (frag_fire) begin
				held_q[c] <= held_n;
				asm_q[c]  <= asm_n;
				fail_q[c] <= fail_n;
				open_q[c] <= !item.frag_end;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1.result_kind    <= rkind;
			res_s1.out_chan       <= item.chan;
			res_s1.out_byte       <= rbyte;
			res_s1.message_length <= rlen;
			res_s1.message_end    <= rend;
			use_mem_s1            <= use_mem;
		end
	end

	// Store write and registered read.
	always_ff @(posedge clk) begin
		if (frag_fire && wr_en) begin
			store_q[wr_addr] <= item.payload_byte;
		end
		if (fire && use_mem) begin
			rd_byte_s1 <= store_q[rd_addr];
		end
	end

	// Stored bytes join the result on their way to the output queue.
	always_comb begin
		res          = res_s1;
		res.out_byte = use_mem_s1 ? rd_byte_s1 : res_s1.out_byte;
	end
	assign res_valid = res_valid_s1;
endmodule
`default_nettype wire

// ===== rtl/multichannel_fragment_reassembler.sv =====
// Multichannel fragment reassembler. Takes one request per cycle, sustained, while
// the result queue has room, and gives back one result per cycle when the sink keeps
// ready high. A request is a fragment byte or a read of a stored byte; a result
// reaches the output after passing, in order, the input register, the request
// queue, the result stage and the output queue. The front registers and
// range-checks each request; a four-entry queue separates it from the back, which
// keeps per-channel length and status in flip-flops, so consecutive bytes of one
// channel need no wait, and holds the messages in a store with one write and one
// registered read port. The back issues a request only when the four-entry result
// queue has room for its answer, so the block takes new requests while finished
// results wait. The store is not cleared at reset and needs no start-up pass.
`default_nettype none
module multichannel_fragment_reassembler #(
	parameter int NUM_CHANNELS      = mfr_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_MESSAGE_BYTES = mfr_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mfr_req_if.sink     req,
	mfr_rsp_if.source   rsp
);
	import mfr_pkg::*;

	localparam int IW = $bits(item_t);
	localparam int RW = $bits(rsp_t);

	logic                 f_valid;
	logic                 f_ready;
	item_t                f_item;
	logic                 q_valid;
	logic                 q_ready;
	logic [IW-1:0]        q_data;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
	logic                 r_valid;
	logic                 r_ready;
	rsp_t                 r_data;
	rsp_t                 o_data;
	logic [OUT_CNT_W-1:0] o_count;

	// Front: take and classify requests.
	mfr_front #(
		.NUM_CHANNELS      (NUM_CHANNELS),
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	// Request queue between front and back.
	mfr_fifo #(
		.WIDTH (IW),
		.DEPTH (QUEUE_DEPTH)
	) u_req_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data),
		.count      (q_count)
	);

	// Back: reassembly state and the message store.
	mfr_back #(
		.NUM_CHANNELS      (NUM_CHANNELS),
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.item       (item_t'(q_data)),
		.out_count  (o_count),
		.res_valid  (r_valid),
		.res        (r_data)
	);

	// Result queue in front of the output port.
	mfr_fifo #(
		.WIDTH (RW),
		.DEPTH (OUT_DEPTH)
	) u_rsp_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (r_valid),
		.push_ready (r_ready),
		.push_data  (r_data),
		.pop_valid  (rsp.valid),
		.pop_ready  (rsp.ready),
		.pop_data   (o_data),
		.count      (o_count)
	);

	// Output payload.
	assign rsp.result_kind    = o_data.result_kind;
	assign rsp.out_chan       = o_data.out_chan;
	assign rsp.out_byte       = o_data.out_byte;
	assign rsp.message_length = o_data.message_length;
	assign rsp.message_end    = o_data.message_end;

	// The back only issues with room reserved, so the push side never stalls and
	// the request queue fill level is for observation only.
	logic unused_ok;
	assign unused_ok = r_ready ^ (^q_count);
endmodule
`default_nettype wire

// ===== rtl/mfr_checker.sv =====
// Port-level checker of the fragment reassembler and its bind.
`default_nettype none
`include "multichannel_fragment_reassembler_defines.svh"
module mfr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  result_kind,
	input wire logic [7:0]  out_chan,
	input wire logic [7:0]  out_byte,
	input wire logic [12:0] message_length,
	input wire logic        message_end
);
	import mfr_pkg::*;

	localparam int PW = $clog2(MAX_PENDING + 2);

	logic [PW-1:0] pend_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = req_valid && req_ready;
	assign out_acc = rsp_valid && rsp_ready;

	// Credit of requests taken that may still owe a result. Requests without a result
	// also count, so the credit saturates at the most the block can hold at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			if (pend_q != PW'(MAX_PENDING)) begin
				pend_q <= pend_q + 1'b1;
			end
		end else if (out_acc && !in_acc && pend_q != '0) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	`MFR_ASSERT_ALWAYS(a_no_invented_result, clk, arst_n, !out_acc || pend_q != '0, "result without a pending request")
	`MFR_ASSERT_ALWAYS(a_length_only_on_done, clk, arst_n, !rsp_valid || result_kind == RK_DONE || message_length == '0, "length on a result that is not a completion")
	`MFR_ASSERT_NEXT(a_rsp_valid_holds, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result withdrawn while stalled")
	`MFR_ASSERT_NEXT(a_rsp_data_holds, clk, arst_n, rsp_valid && !rsp_ready, $stable({result_kind, out_chan, out_byte, message_length, message_end}), "result changed while stalled")
endmodule

bind multichannel_fragment_reassembler mfr_checker u_mfr_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.result_kind    (rsp.result_kind),
	.out_chan       (rsp.out_chan),
	.out_byte       (rsp.out_byte),
	.message_length (rsp.message_length),
	.message_end    (rsp.message_end)
);
`default_nettype wire

// ===== bench/mfr_result_checker.sv =====
// Checker that predicts the reassembler results from the accepted requests and compares them.
module mfr_result_checker #(
	parameter int NUM_CH    = mfr_pkg::NUM_CHANNELS_DEF,
	parameter int MAX_BYTES = mfr_pkg::MAX_MESSAGE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mfr_req_if          req_mon,
	mfr_rsp_if          rsp_mon,
	output int          fail_count,
	output int          pending_count,
	output int          results_checked,
	output int unsigned stored_extent [NUM_CH]
);
	timeunit 1ns;
	timeprecision 1ps;
	import mfr_pkg::*;

	// Predicted block state; all of it but the message store starts at its reset value.
	logic [7:0]  message_mem [NUM_CH * MAX_BYTES];
	int unsigned held_bytes [NUM_CH];
	bit          assembling [NUM_CH];
	bit          frag_failed [NUM_CH];
	bit          frag_open [NUM_CH];
	int unsigned high_water [NUM_CH];

	// Results still owed by the block, oldest first.
	rsp_t        expected_results [$];
	int          mismatches;
	int          reported;
	int          checked;

	task automatic drop_message(input int c);
		held_bytes[c] = 0;
		assembling[c] = 1'b0;
	endtask

	// Appends one byte, or fails the fragment when the store is full.
	task automatic append_payload(input int c, input logic [7:0] data);
		if (held_bytes[c] >= MAX_BYTES) begin
			frag_failed[c] = 1'b1;
			drop_message(c);
		end else begin
			message_mem[c * MAX_BYTES + int'(held_bytes[c])] = data;
			held_bytes[c]++;
			if (held_bytes[c] > high_water[c])
				high_water[c] = held_bytes[c];
		end
	endtask

	// Updates the predicted state for one accepted request and queues its result, if any.
	task automatic predict_request(input logic act, input logic [7:0] ch, input logic [2:0] kind,
			input logic [7:0] data, input logic fend, input logic [11:0] ofs);
		rsp_t r;
		int   c;
		r = '0;
		r.out_chan = ch;
		c = int'(ch);

		// A read answers at once; bad channels and offsets read as zero.
		if (act == ACT_READ) begin
			r.result_kind = RK_READ;
			if (c < NUM_CH && int'(ofs) < MAX_BYTES)
				r.out_byte = message_mem[c * MAX_BYTES + int'(ofs)];
			expected_results.push_back(r);
			return;
		end

		// Bytes on a bad channel are dropped; the fragment end reports an error.
		if (c >= NUM_CH) begin
			if (fend) begin
				r.result_kind = RK_ERR;
				expected_results.push_back(r);
			end
			return;
		end

		// A single byte passes through and resets the channel.
		if (kind == FK_SINGLE) begin
			drop_message(c);
			frag_failed[c] = 1'b0;
			frag_open[c] = !fend;
			r.result_kind = RK_PASS;
			r.out_byte = data;
			r.message_end = fend;
			expected_results.push_back(r);
			return;
		end

		// The first byte of a first fragment starts a fresh message.
		if (kind == FK_FIRST && !frag_open[c]) begin
			drop_message(c);
			frag_failed[c] = 1'b0;
			assembling[c] = 1'b1;
		end

		if (kind > FK_LAST) begin
			frag_failed[c] = 1'b1;
			drop_message(c);
		end else if (!frag_failed[c]) begin
			if (!assembling[c])
				frag_failed[c] = 1'b1;
			else
				append_payload(c, data);
		end

		frag_open[c] = !fend;
		if (!fend)
			return;

		// At the fragment end, report an error or a finished message.
		if (frag_failed[c]) begin
			frag_failed[c] = 1'b0;
			r.result_kind = RK_ERR;
			expected_results.push_back(r);
		end else if (kind == FK_LAST) begin
			r.result_kind = RK_DONE;
			r.message_length = 13'(held_bytes[c]);
			drop_message(c);
			expected_results.push_back(r);
		end
	endtask

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			mismatches++;
			if (reported < 40) begin
				reported++;
				$display("time %0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, name, want, got);
			end
		end
	endtask

	// Predict on every accepted request and check every accepted result.
	always @(posedge clk) begin : watch
		rsp_t seen;
		rsp_t want;
		if (arst_n) begin
			if (req_mon.valid && req_mon.ready)
				predict_request(req_mon.action, req_mon.chan, req_mon.frag_kind,
					req_mon.payload_byte, req_mon.frag_end, req_mon.read_offset);
			if (rsp_mon.valid && rsp_mon.ready) begin
				seen.result_kind = rsp_mon.result_kind;
				seen.out_chan = rsp_mon.out_chan;
				seen.out_byte = rsp_mon.out_byte;
				seen.message_length = rsp_mon.message_length;
				seen.message_end = rsp_mon.message_end;
				checked++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (reported < 40) begin
						reported++;
						$display("time %0t: unexpected result, expected none, actual %p",
							$time, seen);
					end
				end else begin
					want = expected_results.pop_front();
					compare_field("result_kind", 16'(want.result_kind), 16'(seen.result_kind));
					compare_field("out_chan", 16'(want.out_chan), 16'(seen.out_chan));
					compare_field("out_byte", 16'(want.out_byte), 16'(seen.out_byte));
					compare_field("message_length", 16'(want.message_length),
						16'(seen.message_length));
					compare_field("message_end", 16'(want.message_end), 16'(seen.message_end));
				end
			end
		end
		fail_count <= mismatches;
		pending_count <= expected_results.size();
		results_checked <= checked;
		stored_extent <= high_water;
	end

endmodule

// ===== bench/tb_multichannel_fragment_reassembler.sv =====
// Top of the reassembler testbench: clock, reset, request stimulus, result sink and verdict.
module tb_multichannel_fragment_reassembler;
	timeunit 1ns;
	timeprecision 1ps;
	import mfr_pkg::*;

	localparam int NUM_CH       = NUM_CHANNELS_DEF;
	localparam int MAX_BYTES    = MAX_MESSAGE_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1560;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int DRAIN_CYCLES = 32;

	// Fragment kinds outside the defined set.
	localparam logic [2:0] FK_UNKNOWN_LO = 3'd4;
	localparam logic [2:0] FK_UNKNOWN_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	mfr_req_if   req ();
	mfr_rsp_if   rsp ();

	int          fail_count;
	int          pending_count;
	int          results_checked;
	int unsigned stored_extent [NUM_CH];

	int          items_sent;
	int          cycle_count;
	int          stall_left;
	bit          sender_steady;
	bit          sink_steady;
	bit          in_message [NUM_CH];

	multichannel_fragment_reassembler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mfr_result_checker #(
		.NUM_CH    (NUM_CH),
		.MAX_BYTES (MAX_BYTES)
	) result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_mon         (req),
		.rsp_mon         (rsp),
		.fail_count      (fail_count),
		.pending_count   (pending_count),
		.results_checked (results_checked),
		.stored_extent   (stored_extent)
	);

	always #5 clk = ~clk;

	// Idle length: mostly none, often short, now and then long.
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// Fragment length: mostly a few bytes, sometimes a few dozen.
	function automatic int frag_length();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(4, 1);
		else if (r < 95)
			return $urandom_range(16, 5);
		return $urandom_range(64, 17);
	endfunction

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result sink with random stalls and stretches of steady acceptance.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
			if (!sink_steady && $urandom_range(99) < 25)
				stall_left <= idle_cycles();
		end
		if (cycle_count % 512 == 0)
			sink_steady <= ($urandom_range(3) == 0);
	end

	// Offers one request and returns at the edge where it is accepted.
	task automatic send_request(input logic act, input logic [7:0] ch, input logic [2:0] kind,
			input logic [7:0] data, input logic fend, input logic [11:0] ofs);
		int gap;
		gap = sender_steady ? 0 : idle_cycles();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.chan <= ch;
		req.frag_kind <= kind;
		req.payload_byte <= data;
		req.frag_end <= fend;
		req.read_offset <= ofs;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		items_sent++;
		if (items_sent % 256 == 0)
			sender_steady = ($urandom_range(3) == 0);
	endtask

	// One fragment of random bytes, all of the same kind.
	task automatic send_fragment(input logic [7:0] ch, input logic [2:0] kind, input int len);
		for (int i = 0; i < len; i++)
			send_request(ACT_FRAG, ch, kind, 8'($urandom), i == len - 1, 12'($urandom));
	endtask

	// A read of a written byte, or now and then a read on a bad channel.
	task automatic send_read();
		int          c;
		int unsigned span;
		c = $urandom_range(NUM_CH - 1);
		span = stored_extent[c];
		if (span == 0 || $urandom_range(9) == 0)
			send_request(ACT_READ, 8'($urandom_range(255, NUM_CH)), 3'($urandom),
				8'($urandom), 1'($urandom), 12'($urandom));
		else
			send_request(ACT_READ, 8'(c), 3'($urandom), 8'($urandom), 1'($urandom),
				12'($urandom_range(span - 1)));
	endtask

	initial begin : stimulus
		int roll;
		int c;
		int len;
		int random_start;

		clk = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_FRAG;
		req.chan = '0;
		req.frag_kind = FK_SINGLE;
		req.payload_byte = '0;
		req.frag_end = 1'b0;
		req.read_offset = '0;
		rsp.ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Pass-through bytes with extreme values and channels.
		send_request(ACT_FRAG, 8'd0, FK_SINGLE, 8'h00, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd7, FK_SINGLE, 8'hFF, 1'b0, 12'hFFF);
		send_request(ACT_FRAG, 8'd7, FK_SINGLE, 8'hA5, 1'b1, 12'h000);
		// Shortest complete message, then read back.
		send_request(ACT_FRAG, 8'd1, FK_FIRST, 8'h11, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd1, FK_LAST, 8'h22, 1'b1, 12'h000);
		send_request(ACT_READ, 8'd1, FK_SINGLE, 8'h00, 1'b0, 12'd0);
		send_request(ACT_READ, 8'd1, FK_SINGLE, 8'h00, 1'b0, 12'd1);
		// Orphan continuation and orphan last.
		send_request(ACT_FRAG, 8'd2, FK_CONT, 8'h33, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd3, FK_LAST, 8'h44, 1'b1, 12'h000);
		// Unknown kinds, one and two bytes long.
		send_request(ACT_FRAG, 8'd4, FK_UNKNOWN_HI, 8'h55, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd4, FK_UNKNOWN_LO, 8'h66, 1'b0, 12'h000);
		send_request(ACT_FRAG, 8'd4, FK_UNKNOWN_LO, 8'h77, 1'b1, 12'h000);
		// Bad channels, including a bad single and a bad read.
		send_request(ACT_FRAG, 8'd255, FK_FIRST, 8'h88, 1'b0, 12'h000);
		send_request(ACT_FRAG, 8'd255, FK_LAST, 8'h99, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd8, FK_SINGLE, 8'hAA, 1'b1, 12'h000);
		send_request(ACT_READ, 8'd200, FK_SINGLE, 8'h00, 1'b0, 12'd4095);
		// A single drops the message in progress, so the last is an orphan.
		send_request(ACT_FRAG, 8'd5, FK_FIRST, 8'h01, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd5, FK_SINGLE, 8'h02, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd5, FK_LAST, 8'h03, 1'b1, 12'h000);
		// A second first fragment restarts the message.
		send_request(ACT_FRAG, 8'd6, FK_FIRST, 8'h04, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd6, FK_FIRST, 8'h05, 1'b1, 12'h000);
		send_request(ACT_FRAG, 8'd6, FK_LAST, 8'h06, 1'b1, 12'h000);
		send_request(ACT_READ, 8'd6, FK_SINGLE, 8'h00, 1'b0, 12'd0);

		// Random mix: mostly well-formed messages, some reads, some broken traffic.
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			roll = $urandom_range(99);
			c = $urandom_range(NUM_CH - 1);
			len = frag_length();
			if (roll < 12) begin
				send_read();
			end else if (roll < 20) begin
				case ($urandom_range(3))
					0: begin
						send_fragment(8'(c), 3'($urandom_range(FK_UNKNOWN_HI, FK_UNKNOWN_LO)),
							$urandom_range(3, 1));
						in_message[c] = 1'b0;
					end
					1: begin
						send_fragment(8'($urandom_range(255, NUM_CH)), 3'($urandom),
							$urandom_range(3, 1));
					end
					2: begin
						send_fragment(8'(c), $urandom_range(1) ? FK_CONT : FK_LAST,
							$urandom_range(3, 1));
						in_message[c] = 1'b0;
					end
					default: begin
						// Kinds change from byte to byte within one fragment.
						for (int i = 0; i < len; i++)
							send_request(ACT_FRAG, 8'(c), 3'($urandom), 8'($urandom),
								i == len - 1, 12'($urandom));
						in_message[c] = 1'b0;
					end
				endcase
			end else if (!in_message[c]) begin
				if ($urandom_range(4) == 0) begin
					send_fragment(8'(c), FK_SINGLE, len);
				end else begin
					send_fragment(8'(c), FK_FIRST, len);
					in_message[c] = 1'b1;
				end
			end else begin
				roll = $urandom_range(9);
				if (roll < 5) begin
					send_fragment(8'(c), FK_CONT, len);
				end else if (roll < 8) begin
					send_fragment(8'(c), FK_LAST, len);
					in_message[c] = 1'b0;
				end else if (roll == 8) begin
					send_fragment(8'(c), FK_SINGLE, len);
					in_message[c] = 1'b0;
				end else begin
					send_fragment(8'(c), FK_FIRST, len);
				end
			end
		end
		req.valid <= 1'b0;

		// Wait for every owed result, then a little longer for strays.
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d requests, %0d of them in the random mix, and checked %0d results.",
			items_sent, items_sent - random_start, results_checked);
		$display("Covered multi-fragment messages, restarts, orphans, unknown kinds, "
			, "bad channels and read-back.");
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
